### hw/rtl/halfduplex_link_timeout_fsm_core_assert.svh
// assertion macros for the half-duplex link sequencer
// expects clk and rst_n in the scope of each use
`ifndef HALFDUPLEX_LINK_TIMEOUT_FSM_CORE_ASSERT_SVH
`define HALFDUPLEX_LINK_TIMEOUT_FSM_CORE_ASSERT_SVH

// same-cycle implication
`define HDLT_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("hdlt: same-cycle check failed");

// next-cycle implication
`define HDLT_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("hdlt: next-cycle check failed");

`endif

### hw/rtl/hdlt_pkg.sv
// shared types and constants for the half-duplex link sequencer
// no dependencies
package hdlt_pkg;

  localparam int CountWidth   = 16;
  localparam int TimeWidth    = 32;
  localparam int LimitWidth   = 32;
  localparam int StatusWidth  = 10;
  localparam int LenWidth     = 16;
  localparam int InDataWidth  = 144;
  localparam int OutDataWidth = 24;

  localparam logic [StatusWidth-1:0] TX_DONE_BITS = 10'h210;
  localparam logic [StatusWidth-1:0] RX_ERR_BITS  = 10'h0E4;

  typedef enum logic [1:0] {
    ACT_TICK  = 2'd0,
    ACT_READ  = 2'd1,
    ACT_WRITE = 2'd2,
    ACT_NOP   = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    PH_IDLE       = 2'd0,
    PH_WRITE      = 2'd1,
    PH_WAIT_FIRST = 2'd2,
    PH_READ       = 2'd3
  } phase_t;

  typedef struct packed {
    action_t                action;
    logic [TimeWidth-1:0]   now_ms;
    logic [CountWidth-1:0]  dma_remaining;
    logic [StatusWidth-1:0] uart_status;
    logic [CountWidth-1:0]  buffer_len;
    logic [LimitWidth-1:0]  first_timeout;
    logic [LimitWidth-1:0]  gap_timeout;
  } item_t;

  typedef struct packed {
    phase_t                phase;
    logic [CountWidth-1:0] last_count;
    logic [TimeWidth-1:0]  window_start;
    logic [LimitWidth-1:0] first_limit;
    logic [LimitWidth-1:0] gap_limit;
    logic [CountWidth-1:0] capacity;
    logic [CountWidth-1:0] length;
    logic                  flag_rx;
    logic                  flag_tx;
    logic                  flag_en;
  } link_state_t;

  typedef struct packed {
    logic accepted;
    logic rx_error;
  } step_flags_t;

endpackage

### hw/rtl/hdlt_step.sv
// next-state and result logic for one item of the link sequencer
// depends on hdlt_pkg
module hdlt_step (
  input  logic                 connected,
  input  hdlt_pkg::item_t       item,
  input  hdlt_pkg::link_state_t st_cur,
  output hdlt_pkg::link_state_t st_nxt,
  output hdlt_pkg::step_flags_t flags
);
  import hdlt_pkg::*;

  logic [TimeWidth-1:0]  elapsed;
  logic [LimitWidth-1:0] limit;
  logic [CountWidth-1:0] rx_len;
  logic                  count_same;
  logic                  timed_out;
  logic                  rx_err_hit;
  logic                  tx_done_hit;

  assign elapsed     = item.now_ms - st_cur.window_start;
  assign limit       = (st_cur.phase == PH_WAIT_FIRST) ? st_cur.first_limit : st_cur.gap_limit;
  assign rx_len      = (st_cur.capacity >= st_cur.last_count) ?
                       (st_cur.capacity - st_cur.last_count) : '0;
  assign count_same  = (item.dma_remaining == st_cur.last_count);
  assign timed_out   = (elapsed >= limit);
  assign rx_err_hit  = |(item.uart_status & RX_ERR_BITS);
  assign tx_done_hit = ((item.uart_status & TX_DONE_BITS) == TX_DONE_BITS);

  always_comb begin
    st_nxt = st_cur;
    flags  = '0;
    case (item.action)
      ACT_READ: begin
        if (st_cur.phase == PH_IDLE) begin
          flags.accepted      = 1'b1;
          st_nxt.capacity     = item.buffer_len;
          st_nxt.first_limit  = item.first_timeout;
          st_nxt.gap_limit    = item.gap_timeout;
          st_nxt.last_count   = item.buffer_len;
          st_nxt.window_start = item.now_ms;
          st_nxt.length       = '0;
          st_nxt.flag_rx      = 1'b0;
          st_nxt.flag_en      = 1'b0;
          st_nxt.phase        = PH_WAIT_FIRST;
        end
      end
      ACT_WRITE: begin
        if (st_cur.phase == PH_IDLE) begin
          flags.accepted = 1'b1;
          st_nxt.flag_tx = 1'b0;
          st_nxt.flag_en = 1'b1;
          st_nxt.phase   = PH_WRITE;
        end
      end
      ACT_TICK: begin
        if (!connected) begin
          st_nxt.phase   = PH_IDLE;
          st_nxt.flag_en = 1'b0;
        end
        case (st_nxt.phase)
          PH_WRITE: begin
            if (tx_done_hit) begin
              st_nxt.flag_tx = 1'b1;
              st_nxt.flag_en = 1'b0;
              st_nxt.phase   = PH_IDLE;
            end
          end
          PH_WAIT_FIRST, PH_READ: begin
            if ((st_nxt.phase == PH_READ) && rx_err_hit) begin
              st_nxt.flag_en = 1'b0;
              st_nxt.phase   = PH_IDLE;
              flags.rx_error = 1'b1;
            end else if (count_same) begin
              if (timed_out) begin
                st_nxt.length  = rx_len;
                st_nxt.flag_rx = (rx_len != '0);
                st_nxt.phase   = PH_IDLE;
              end
            end else begin
              st_nxt.last_count   = item.dma_remaining;
              st_nxt.window_start = item.now_ms;
              st_nxt.phase        = PH_READ;
            end
          end
          default: ;
        endcase
      end
      default: ;
    endcase
  end

endmodule

### hw/rtl/halfduplex_link_timeout_fsm_core.sv
// top level of the half-duplex link sequencer: input register, state, result register
// depends on hdlt_pkg, hdlt_step and halfduplex_link_timeout_fsm_core_assert.svh
//
// Takes one transfer per clock while the input register can move forward and returns
// one result transfer per input transfer once the output side is ready; each item is
// held in the input register, then in the result register. The rate is one item per
// cycle, set by the single compare-and-update path from the input register through the
// state to the result register; both sides may stall freely and the input side keeps
// taking transfers while a result waits, as long as the input register can move forward.
module halfduplex_link_timeout_fsm_core (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  cfg_wr_en,
  input  logic                                  cfg_wr_data,   // port_connected
  input  logic                                  in_tvalid,
  output logic                                  in_tready,
  // now_ms[31:0], dma_remaining[47:32], uart_status[57:48], buffer_len[73:58],
  // first_timeout[105:74], gap_timeout[137:106], zero pad[143:138]
  input  logic [hdlt_pkg::InDataWidth-1:0]      in_tdata,
  input  logic [1:0]                            in_tuser,      // action
  output logic                                  out_tvalid,
  input  logic                                  out_tready,
  // accepted[0], busy_res[1], phase[3:2], tx_done[4], rx_received[5],
  // rx_length[21:6], rx_error[22], driver_enable[23]
  output logic [hdlt_pkg::OutDataWidth-1:0]     out_tdata
);
  import hdlt_pkg::*;

  `include "halfduplex_link_timeout_fsm_core_assert.svh"

  logic                    connected_r;
  logic                    in_valid_r;
  item_t                   item_r;
  item_t                   item_nxt;
  link_state_t             st_r;
  link_state_t             st_nxt;
  step_flags_t             flags;
  logic                    out_valid_r;
  logic [OutDataWidth-1:0] out_data_r;
  logic [OutDataWidth-1:0] out_data_nxt;
  logic                    adv;
  logic                    write_taken;

  assign adv       = in_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !in_valid_r || adv;

  assign item_nxt.action        = action_t'(in_tuser);
  assign item_nxt.now_ms        = in_tdata[31:0];
  assign item_nxt.dma_remaining = in_tdata[47:32];
  assign item_nxt.uart_status   = in_tdata[57:48];
  assign item_nxt.buffer_len    = in_tdata[73:58];
  assign item_nxt.first_timeout = in_tdata[105:74];
  assign item_nxt.gap_timeout   = in_tdata[137:106];

  hdlt_step u_step (
    .connected (connected_r),
    .item      (item_r),
    .st_cur    (st_r),
    .st_nxt    (st_nxt),
    .flags     (flags)
  );

  assign out_data_nxt = {st_nxt.flag_en,
                         flags.rx_error,
                         st_nxt.length[LenWidth-1:0],
                         st_nxt.flag_rx,
                         st_nxt.flag_tx,
                         st_nxt.phase,
                         (st_nxt.phase != PH_IDLE),
                         flags.accepted};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      connected_r <= 1'b0;
    end else if (cfg_wr_en) begin
      connected_r <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      item_r <= item_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= '{phase: PH_IDLE, default: '0};
    end else if (adv) begin
      st_r <= st_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  assign write_taken = adv && (item_r.action == ACT_WRITE) && (st_r.phase == PH_IDLE);

  // driver enable only while a write is in progress
  `HDLT_ASSERT_NOW(a_en_only_writing, st_r.phase != PH_WRITE, !st_r.flag_en)
  // a write start taken in idle moves to writing
  `HDLT_ASSERT_NEXT(a_write_start, write_taken, st_r.phase == PH_WRITE && st_r.flag_en)
  // an error abort always reports idle phase
  `HDLT_ASSERT_NOW(a_err_idle, out_valid_r && out_data_r[22], out_data_r[3:2] == PH_IDLE && !out_data_r[1])

endmodule
